/* rtl/core/tsc_pkg.sv */
// Package for the thermostat setpoint controller.
// Holds the shared codes, reset values, arithmetic constants and the
// controller-to-datapath command and status types. Depends on nothing.
package tsc_pkg;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_FLOOR   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CEILING = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MARGIN  = 2'd2;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;
  localparam logic [1:0] MODE_HIGH = 2'd2;

  localparam logic [1:0] RANGE_BELOW  = 2'd0;
  localparam logic [1:0] RANGE_ABOVE  = 2'd1;
  localparam logic [1:0] RANGE_WITHIN = 2'd2;

  localparam logic [1:0] SAVE_NONE = 2'd0;
  localparam logic [1:0] SAVE_LOW  = 2'd1;
  localparam logic [1:0] SAVE_HIGH = 2'd2;

  localparam logic [7:0] FLOOR_RESET   = 8'd50;
  localparam logic [7:0] CEILING_RESET = 8'd90;
  localparam logic [3:0] MARGIN_RESET  = 4'd3;
  localparam logic [7:0] LOW_RESET     = 8'd60;
  localparam logic [7:0] HIGH_RESET    = 8'd90;
  localparam logic [7:0] WIDTH_RESET   = 8'd23;

  localparam logic [7:0] WIDTH_HIGH_MAX = 8'd35;
  localparam logic [7:0] WIDTH_LOW_MIN  = 8'd11;
  localparam logic [7:0] DIAL_BASE      = 8'd47;

  localparam logic signed [17:0] OFFSET_32F  = 18'sd320;
  localparam logic signed [17:0] TENTHS_MIN  = -18'sd1024;
  localparam logic signed [17:0] TENTHS_MAX  = 18'sd4095;
  localparam logic [17:0]        RECIP5      = 18'd209716;
  localparam int unsigned        RECIP5_SH   = 20;
  localparam logic [12:0]        RECIP10     = 13'd6554;
  localparam int unsigned        RECIP10_SH  = 16;

  typedef struct packed {
    logic load;
    logic mul10;
    logic mul9;
    logic div5;
    logic offs;
    logic div10;
    logic whole;
    logic enc;
    logic check;
    logic alarm;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Dial servo width for a whole-degree value, before any clamping.
  function automatic logic [7:0] dial_width(input logic [7:0] t);
    logic [14:0] prod;
    logic [7:0]  q;
    prod = 15'(t) * 15'd102 + 15'd16;
    q    = prod[14:8] < 7'(DIAL_BASE) ? 8'(prod[14:8]) : DIAL_BASE;
    return DIAL_BASE - q;
  endfunction

endpackage

/* rtl/core/tsc_ctrl.sv */
// Sequencing state machine of the thermostat setpoint controller.
// Issues one datapath command per cycle for each accepted word,
// stalling at emit while the output is full. Depends on tsc_pkg.
module tsc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_reading_i,
  output logic            in_ready_o,
  input  tsc_pkg::status_t status_i,
  output tsc_pkg::cmd_t   cmd_o
);
  import tsc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL10 = 4'd1;
  localparam logic [3:0] S_MUL9  = 4'd2;
  localparam logic [3:0] S_DIV5  = 4'd3;
  localparam logic [3:0] S_OFFS  = 4'd4;
  localparam logic [3:0] S_DIV10 = 4'd5;
  localparam logic [3:0] S_WHOLE = 4'd6;
  localparam logic [3:0] S_ENC   = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;
  localparam logic [3:0] S_ALARM = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = in_reading_i ? S_MUL10 : S_ENC;
        end
      end
      S_MUL10: begin
        cmd_o.mul10 = 1'b1;
        state_d     = S_MUL9;
      end
      S_MUL9: begin
        cmd_o.mul9 = 1'b1;
        state_d    = S_DIV5;
      end
      S_DIV5: begin
        cmd_o.div5 = 1'b1;
        state_d    = S_OFFS;
      end
      S_OFFS: begin
        cmd_o.offs = 1'b1;
        state_d    = S_DIV10;
      end
      S_DIV10: begin
        cmd_o.div10 = 1'b1;
        state_d     = S_WHOLE;
      end
      S_WHOLE: begin
        cmd_o.whole = 1'b1;
        state_d     = S_ENC;
      end
      S_ENC: begin
        cmd_o.enc = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_ALARM;
      end
      S_ALARM: begin
        cmd_o.alarm = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("More than one datapath command in a cycle.");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("Result emitted into a full output register.");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MUL10 || state_q == S_ENC))
    else $error("Accepted word did not start processing.");

endmodule

/* rtl/core/tsc_datapath.sv */
// Datapath of the thermostat setpoint controller: reading conversion,
// encoder and setpoint logic, alarm latch and output register.
// Depends on tsc_pkg; driven by commands from tsc_ctrl.
module tsc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tsc_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [tsc_pkg::InDataW-1:0]       in_data_i,
  input  tsc_pkg::cmd_t                     cmd_i,
  output tsc_pkg::status_t                  status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tsc_pkg::OutDataW-1:0]      out_data_o
);
  import tsc_pkg::*;

  logic [7:0] floor_q, ceiling_q;
  logic [3:0] margin_q;

  logic              enc_a_q, enc_b_q, low_btn_q, high_btn_q;
  logic signed [15:0] raw_q;

  logic signed [15:0] v1_q;
  logic               neg_q;
  logic [17:0]        m9_q;
  logic [15:0]        q5_q;
  logic signed [12:0] tenths_q;
  logic [8:0]         wq_q;
  logic [7:0]         whole_q;
  logic [3:0]         digit_q;
  logic [7:0]         width_q;

  logic [1:0] phase_q;
  logic       phase_known_q;
  logic [1:0] mode_q;
  logic [7:0] low_q, high_q, last_low_q, last_high_q;
  logic [1:0] saved_q, range_q;
  logic       alarm_q, start_q;

  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_q;

  logic signed [19:0] p10, p9;
  logic [35:0]        p5;
  logic signed [17:0] t_sum;
  logic [25:0]        p10r;
  logic [11:0]        digit_full;
  logic [7:0]         whole_sat;
  logic [1:0]         mode_n, phase_n;
  logic               dir_up, dir_dn;
  logic [7:0]         low_n, high_n;
  logic [7:0]         low_c, high_c, dial_sp, width_sp;
  logic [8:0]         whole_pm, low_pm, high_pm;
  logic               set_cond, clr_cond;

  assign p10   = 20'(raw_q) * 20'sd10;
  assign p9    = 20'(v1_q) * 20'sd9;
  assign p5    = 36'(m9_q) * 36'(RECIP5);
  assign t_sum = neg_q ? OFFSET_32F - 18'($signed({2'b00, q5_q}))
                       : OFFSET_32F + 18'($signed({2'b00, q5_q}));
  assign p10r  = 26'(tenths_q[11:0]) * 26'(RECIP10);

  assign whole_sat  = tenths_q[12] ? 8'd0 : (wq_q[8] ? 8'd255 : wq_q[7:0]);
  assign digit_full = tenths_q[11:0] - {wq_q, 3'b000} - {2'b00, wq_q, 1'b0};

  always_comb begin
    mode_n = mode_q;
    if (low_btn_q) mode_n = MODE_LOW;
    if (high_btn_q) mode_n = MODE_HIGH;

    phase_n = phase_q;
    dir_up  = 1'b0;
    dir_dn  = 1'b0;
    if (!phase_known_q) begin
      phase_n = {enc_b_q, enc_a_q};
    end else begin
      case (phase_q)
        2'd0: begin
          if (enc_a_q) begin
            phase_n = 2'd1; dir_up = 1'b1;
          end else if (enc_b_q) begin
            phase_n = 2'd2; dir_dn = 1'b1;
          end
        end
        2'd1: begin
          if (enc_b_q) begin
            phase_n = 2'd3; dir_up = 1'b1;
          end else if (!enc_a_q) begin
            phase_n = 2'd0; dir_dn = 1'b1;
          end
        end
        2'd2: begin
          if (!enc_b_q) begin
            phase_n = 2'd0; dir_up = 1'b1;
          end else if (enc_a_q) begin
            phase_n = 2'd3; dir_dn = 1'b1;
          end
        end
        default: begin
          if (!enc_a_q) begin
            phase_n = 2'd2; dir_up = 1'b1;
          end else if (!enc_b_q) begin
            phase_n = 2'd1; dir_dn = 1'b1;
          end
        end
      endcase
    end

    low_n  = low_q;
    high_n = high_q;
    if (mode_n == MODE_LOW) begin
      if (dir_up) low_n = (low_q >= high_q) ? high_q : low_q + 8'd1;
      else if (dir_dn) low_n = (low_q <= floor_q) ? floor_q : low_q - 8'd1;
    end else if (mode_n == MODE_HIGH) begin
      if (dir_up) high_n = (high_q >= ceiling_q) ? ceiling_q : high_q + 8'd1;
      else if (dir_dn) high_n = (high_q <= low_q) ? low_q : high_q - 8'd1;
    end
  end

  assign high_c  = (high_q <= low_q) ? low_q : high_q;
  assign low_c   = (low_q >= high_q) ? high_q : low_q;
  assign dial_sp = dial_width((mode_q == MODE_HIGH) ? high_c : low_c);
  assign width_sp = (mode_q == MODE_HIGH)
                    ? ((dial_sp > WIDTH_HIGH_MAX) ? WIDTH_HIGH_MAX : dial_sp)
                    : ((dial_sp < WIDTH_LOW_MIN) ? WIDTH_LOW_MIN : dial_sp);

  assign whole_pm = 9'(whole_q) + 9'(margin_q);
  assign low_pm   = 9'(low_q) + 9'(margin_q);
  assign high_pm  = 9'(high_q) + 9'(margin_q);
  assign set_cond = (whole_pm < 9'(low_q)) || (9'(whole_q) > high_pm);
  assign clr_cond = (whole_pm <= 9'(high_q)) && (9'(whole_q) >= low_pm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= FLOOR_RESET;
      ceiling_q <= CEILING_RESET;
      margin_q  <= MARGIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLOOR:   floor_q   <= cfg_data_i;
        CFG_CEILING: ceiling_q <= cfg_data_i;
        CFG_MARGIN:  margin_q  <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      enc_a_q    <= in_data_i[0];
      enc_b_q    <= in_data_i[1];
      low_btn_q  <= in_data_i[2];
      high_btn_q <= in_data_i[3];
      raw_q      <= $signed({in_data_i[11:4], in_data_i[19:12]});
    end
    if (cmd_i.mul10) v1_q <= 16'(p10 >>> 4);
    if (cmd_i.mul9) begin
      neg_q <= p9[19];
      m9_q  <= p9[19] ? 18'(-p9) : 18'(p9);
    end
    if (cmd_i.div5) q5_q <= 16'(p5 >> RECIP5_SH);
    if (cmd_i.div10) wq_q <= tenths_q[12] ? 9'd0 : 9'(p10r >> RECIP10_SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tenths_q      <= '0;
      whole_q       <= '0;
      digit_q       <= '0;
      width_q       <= WIDTH_RESET;
      phase_q       <= '0;
      phase_known_q <= 1'b0;
      mode_q        <= MODE_NONE;
      low_q         <= LOW_RESET;
      high_q        <= HIGH_RESET;
      last_low_q    <= '0;
      last_high_q   <= '0;
      saved_q       <= SAVE_NONE;
      range_q       <= RANGE_WITHIN;
      alarm_q       <= 1'b0;
      start_q       <= 1'b0;
    end else begin
      if (cmd_i.load) saved_q <= SAVE_NONE;
      if (cmd_i.offs) begin
        if (t_sum < TENTHS_MIN) tenths_q <= 13'(TENTHS_MIN);
        else if (t_sum > TENTHS_MAX) tenths_q <= 13'(TENTHS_MAX);
        else tenths_q <= 13'(t_sum);
      end
      if (cmd_i.whole) begin
        whole_q <= whole_sat;
        digit_q <= tenths_q[12] ? 4'd0 : digit_full[3:0];
        width_q <= dial_width(whole_sat);
      end
      if (cmd_i.enc) begin
        mode_q        <= mode_n;
        phase_q       <= phase_n;
        phase_known_q <= 1'b1;
        low_q         <= low_n;
        high_q        <= high_n;
      end
      if (cmd_i.check) begin
        if (mode_q == MODE_HIGH) begin
          high_q <= high_c;
          if (high_c != last_high_q) begin
            last_high_q <= high_c;
            saved_q     <= SAVE_HIGH;
            width_q     <= width_sp;
          end
        end else if (mode_q == MODE_LOW) begin
          low_q <= low_c;
          if (low_c != last_low_q) begin
            last_low_q <= low_c;
            saved_q    <= SAVE_LOW;
            width_q    <= width_sp;
          end
        end
      end
      if (cmd_i.alarm) begin
        start_q <= !alarm_q && set_cond;
        alarm_q <= clr_cond ? 1'b0 : (alarm_q || set_cond);
        if (whole_q < low_q) range_q <= RANGE_BELOW;
        else if (whole_q > high_q) range_q <= RANGE_ABOVE;
        else range_q <= RANGE_WITHIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= {width_q, saved_q, start_q, range_q, mode_q, high_q, low_q,
                digit_q, whole_q, tenths_q};
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.whole |=> (digit_q <= 4'd9))
    else $error("Tenths digit out of range.");

  a_save_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && saved_q == SAVE_HIGH) |-> (last_high_q == high_q))
    else $error("Saved high setpoint does not match the reported one.");

  a_start_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.alarm && !alarm_q && set_cond && !clr_cond) |=> (alarm_q && start_q))
    else $error("Alarm start without a set latch.");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.emit))
    else $error("Output valid without an emitted result.");

endmodule

/* rtl/core/thermostat_setpoint_controller.sv */
// Thermostat setpoint controller top level; depends on tsc_pkg, tsc_ctrl, tsc_datapath.
// A word with a sensor reading runs the conversion steps, then the encoder, check,
// alarm and emit steps; a word without one starts at the encoder step. The sequencer
// handles one word at a time, and the emit step waits for a free output register.
// The result register lets the next word be taken while a result waits.
// Reset (asynchronous, active low) restores setpoints 60/90, floor 50, ceiling 90, margin 3.
module thermostat_setpoint_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tsc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tsc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // enc_a, enc_b, low_button, high_button, sensor_msb, sensor_lsb, zero pad
  input  logic [tsc_pkg::InDataW-1:0]      s_axis_tdata,
  // reading_valid
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // temp_tenths_f, temp_whole, temp_tenth_digit, low_setpoint, high_setpoint,
  // adjust_mode, range_state, alarm_start, setpoint_saved, servo_width
  output logic [tsc_pkg::OutDataW-1:0]     m_axis_tdata
);
  import tsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  tsc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_reading_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  tsc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
